### hw/rtl/bpss_pkg.sv
// Package for the battery power-state supervisor.
// Holds item structs, state and mode codes, register indexes and the level table.
// No dependencies.
package bpss_pkg;

	localparam int MV_W    = 13;
	localparam int MS_W    = 32;
	localparam int CYC_W   = 16;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int TABLE_N = 16;
	localparam int TABLE_W = 4;

	typedef enum logic [1:0] {
		ST_CHARGED  = 2'd0,
		ST_CHARGING = 2'd1,
		ST_LOWPOWER = 2'd2,
		ST_BATTERY  = 2'd3
	} power_state_t;

	typedef enum logic [1:0] {
		MODE_100 = 2'd0,
		MODE_500 = 2'd1,
		MODE_MAX = 2'd2
	} charge_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_MV    = 3'd0,
		REG_CRIT_MV   = 3'd1,
		REG_LOW_TO    = 3'd2,
		REG_CRIT_TO   = 3'd3,
		REG_IDLE_TO   = 3'd4,
		REG_CYC_FAST  = 3'd5,
		REG_CYC_SLOW  = 3'd6,
		REG_AUTO_OFF  = 3'd7
	} cfg_reg_t;

	localparam logic [MV_W-1:0]  RST_LOW_MV   = 13'd3200;
	localparam logic [MV_W-1:0]  RST_CRIT_MV  = 13'd3000;
	localparam logic [MS_W-1:0]  RST_LOW_TO   = 32'd5000;
	localparam logic [MS_W-1:0]  RST_CRIT_TO  = 32'd5000;
	localparam logic [MS_W-1:0]  RST_IDLE_TO  = 32'd300000;
	localparam logic [CYC_W-1:0] RST_CYC_FAST = 16'd500;
	localparam logic [CYC_W-1:0] RST_CYC_SLOW = 16'd1000;
	localparam logic [MV_W-1:0]  RST_MIN_MV   = 13'd6000;

	typedef struct packed {
		logic [MS_W-1:0] now_ms;
		logic [MV_W-1:0] battery_mv;
		logic            charging_active;
		logic            power_good;
		logic            wall_adapter;
		logic [MS_W-1:0] idle_ms;
	} tick_t;

	typedef struct packed {
		logic [1:0]       power_state;
		logic             state_changed;
		logic [1:0]       charge_mode;
		logic             enable_one;
		logic             enable_two;
		logic             may_fly;
		logic             radio_restart;
		logic             system_off;
		logic [CYC_W-1:0] led_on_ms;
		logic [CYC_W-1:0] led_off_ms;
		logic [MV_W-1:0]  min_mv;
		logic [MV_W-1:0]  max_mv;
	} status_t;

	typedef struct packed {
		logic [CYC_W-1:0] fast_period;
		logic [CYC_W-1:0] slow_period;
		logic [CYC_W-1:0] fast_step;
		logic [CYC_W-1:0] slow_step;
		logic             use_fast;
	} led_cfg_t;

	function automatic logic [MV_W-1:0] level_mv(input logic [TABLE_W-1:0] idx);
		logic [MV_W-1:0] mv;
		unique case (idx)
			4'd0:    mv = 13'd3000;
			4'd1:    mv = 13'd3780;
			4'd2:    mv = 13'd3830;
			4'd3:    mv = 13'd3870;
			4'd4:    mv = 13'd3890;
			4'd5:    mv = 13'd3920;
			4'd6:    mv = 13'd3960;
			4'd7:    mv = 13'd4000;
			4'd8:    mv = 13'd4040;
			default: mv = 13'd4100;
		endcase
		return mv;
	endfunction

endpackage

### hw/rtl/battery_power_state_supervisor.sv
// Top level of the battery power-state supervisor.
// Depends on bpss_pkg and bpss_led.
//
// Usage: each item on the tick channel is one poll tick (time, battery voltage,
// charger pins, adapter flag, command idle time). Each tick yields exactly one
// item on the status channel: power state, change flag, charge mode and enables,
// flight flag, radio restart pulse, latched system-off, LED times and the
// voltage extremes. Both channels use valid/stall; an item moves on an edge with
// valid high and stall low.
// A tick passes the input register, then the result register, before it is
// presented on the status channel. Throughput is one tick per cycle while
// status_stall is low; the state update is a single short pass between the
// two registers. When status_stall holds a full result register, it keeps its
// item, the input register takes one more tick if empty, and tick_stall rises.
// Reset: all configuration registers take their default values, the state is
// battery, charge mode 500 mA, flight allowed, shutdown latch clear, minimum
// 6000 mV, maximum 0. The configuration port is a write-only register file
// indexed in list order; the LED step (period / LEVEL_STEPS) is derived as the
// period is written.
module battery_power_state_supervisor #(
	parameter int LEVEL_STEPS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	output logic                            tick_stall,
	input  bpss_pkg::tick_t                 tick,
	output logic                            status_valid,
	input  logic                            status_stall,
	output bpss_pkg::status_t               status,
	input  logic                            cfg_we,
	input  logic [bpss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpss_pkg::CFG_W-1:0]      cfg_data
);

	localparam int CYC_W   = bpss_pkg::CYC_W;
	localparam int RECIP_SH = CYC_W + 5;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'((2 ** RECIP_SH + LEVEL_STEPS - 1) / LEVEL_STEPS);
	localparam logic [CYC_W-1:0] RST_FAST_STEP =
		CYC_W'(int'(bpss_pkg::RST_CYC_FAST) / LEVEL_STEPS);
	localparam logic [CYC_W-1:0] RST_SLOW_STEP =
		CYC_W'(int'(bpss_pkg::RST_CYC_SLOW) / LEVEL_STEPS);

	// configuration
	logic [bpss_pkg::MV_W-1:0] low_mv_q, crit_mv_q;
	logic [bpss_pkg::MS_W-1:0] low_to_q, crit_to_q, idle_to_q;
	logic [CYC_W-1:0]          cyc_fast_q, cyc_slow_q, fast_step_q, slow_step_q;
	logic                      auto_off_q;

	logic [CYC_W+RECIP_W-1:0]  recip_prod;
	logic [CYC_W-1:0]          step_new;

	assign recip_prod = cfg_data[CYC_W-1:0] * RECIP_M;
	assign step_new   = recip_prod[RECIP_SH +: CYC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_mv_q    <= bpss_pkg::RST_LOW_MV;
			crit_mv_q   <= bpss_pkg::RST_CRIT_MV;
			low_to_q    <= bpss_pkg::RST_LOW_TO;
			crit_to_q   <= bpss_pkg::RST_CRIT_TO;
			idle_to_q   <= bpss_pkg::RST_IDLE_TO;
			cyc_fast_q  <= bpss_pkg::RST_CYC_FAST;
			cyc_slow_q  <= bpss_pkg::RST_CYC_SLOW;
			fast_step_q <= RST_FAST_STEP;
			slow_step_q <= RST_SLOW_STEP;
			auto_off_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (bpss_pkg::cfg_reg_t'(cfg_index))
				bpss_pkg::REG_LOW_MV:   low_mv_q  <= cfg_data[bpss_pkg::MV_W-1:0];
				bpss_pkg::REG_CRIT_MV:  crit_mv_q <= cfg_data[bpss_pkg::MV_W-1:0];
				bpss_pkg::REG_LOW_TO:   low_to_q  <= cfg_data;
				bpss_pkg::REG_CRIT_TO:  crit_to_q <= cfg_data;
				bpss_pkg::REG_IDLE_TO:  idle_to_q <= cfg_data;
				bpss_pkg::REG_CYC_FAST: begin
					cyc_fast_q  <= cfg_data[CYC_W-1:0];
					fast_step_q <= step_new;
				end
				bpss_pkg::REG_CYC_SLOW: begin
					cyc_slow_q  <= cfg_data[CYC_W-1:0];
					slow_step_q <= step_new;
				end
				bpss_pkg::REG_AUTO_OFF: auto_off_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake
	logic            valid_s1;
	bpss_pkg::tick_t tick_s1;
	logic            valid_s2;
	bpss_pkg::status_t status_s2;
	logic            advance;

	assign advance    = valid_s1 && (!valid_s2 || !status_stall);
	assign tick_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			tick_s1 <= tick;
		end
	end

	// supervisor state
	bpss_pkg::power_state_t     prev_q, state_n;
	bpss_pkg::charge_mode_t     mode_q, mode_n;
	logic [bpss_pkg::MS_W-1:0]  low_stamp_q, crit_stamp_q, low_stamp_n, crit_stamp_n;
	logic [bpss_pkg::MV_W-1:0]  min_q, max_q, min_n, max_n;
	logic                       fly_q, fly_n, off_q, off_n;
	logic                       changed, restart;
	logic [bpss_pkg::MS_W-1:0]  low_elapsed, crit_elapsed;
	logic [CYC_W-1:0]           led_on, led_off;
	bpss_pkg::led_cfg_t         led_cfg;
	bpss_pkg::status_t          status_n;

	always_comb begin
		max_n = (tick_s1.battery_mv > max_q) ? tick_s1.battery_mv : max_q;
		min_n = (tick_s1.battery_mv < min_q) ? tick_s1.battery_mv : min_q;
		low_stamp_n  = (tick_s1.battery_mv > low_mv_q)  ? tick_s1.now_ms : low_stamp_q;
		crit_stamp_n = (tick_s1.battery_mv > crit_mv_q) ? tick_s1.now_ms : crit_stamp_q;
		low_elapsed  = tick_s1.now_ms - low_stamp_n;
		crit_elapsed = tick_s1.now_ms - crit_stamp_n;

		priority if (tick_s1.power_good && !tick_s1.charging_active) begin
			state_n = bpss_pkg::ST_CHARGED;
		end else if (tick_s1.power_good) begin
			state_n = bpss_pkg::ST_CHARGING;
		end else if (!tick_s1.charging_active && low_elapsed > low_to_q) begin
			state_n = bpss_pkg::ST_LOWPOWER;
		end else begin
			state_n = bpss_pkg::ST_BATTERY;
		end

		changed = (state_n != prev_q);
		mode_n  = mode_q;
		fly_n   = fly_q;
		restart = 1'b0;
		if (changed) begin
			unique case (state_n)
				bpss_pkg::ST_CHARGED: fly_n = 1'b0;
				bpss_pkg::ST_CHARGING: begin
					mode_n  = tick_s1.wall_adapter ? bpss_pkg::MODE_MAX : bpss_pkg::MODE_500;
					fly_n   = 1'b0;
					restart = 1'b1;
				end
				bpss_pkg::ST_LOWPOWER: fly_n = 1'b1;
				default: begin
					fly_n   = 1'b1;
					restart = 1'b1;
				end
			endcase
		end

		off_n = off_q;
		if (state_n == bpss_pkg::ST_LOWPOWER && crit_elapsed > crit_to_q && auto_off_q) begin
			off_n = 1'b1;
		end
		if (state_n == bpss_pkg::ST_BATTERY && tick_s1.idle_ms > idle_to_q && auto_off_q) begin
			off_n = 1'b1;
		end

		led_cfg.fast_period = cyc_fast_q;
		led_cfg.slow_period = cyc_slow_q;
		led_cfg.fast_step   = fast_step_q;
		led_cfg.slow_step   = slow_step_q;
		led_cfg.use_fast    = (mode_n == bpss_pkg::MODE_MAX);

		status_n.power_state   = state_n;
		status_n.state_changed = changed;
		status_n.charge_mode   = mode_n;
		status_n.enable_one    = (mode_n == bpss_pkg::MODE_500);
		status_n.enable_two    = (mode_n == bpss_pkg::MODE_MAX);
		status_n.may_fly       = fly_n;
		status_n.radio_restart = restart;
		status_n.system_off    = off_n;
		status_n.led_on_ms     = (state_n == bpss_pkg::ST_CHARGING) ? led_on : '0;
		status_n.led_off_ms    = (state_n == bpss_pkg::ST_CHARGING) ? led_off : '0;
		status_n.min_mv        = min_n;
		status_n.max_mv        = max_n;
	end

	bpss_led #(
		.LEVEL_STEPS(LEVEL_STEPS)
	) u_led (
		.battery_mv(tick_s1.battery_mv),
		.led_cfg   (led_cfg),
		.led_on_ms (led_on),
		.led_off_ms(led_off)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= bpss_pkg::ST_BATTERY;
			mode_q       <= bpss_pkg::MODE_500;
			low_stamp_q  <= '0;
			crit_stamp_q <= '0;
			min_q        <= bpss_pkg::RST_MIN_MV;
			max_q        <= '0;
			fly_q        <= 1'b1;
			off_q        <= 1'b0;
		end else if (advance) begin
			prev_q       <= state_n;
			mode_q       <= mode_n;
			low_stamp_q  <= low_stamp_n;
			crit_stamp_q <= crit_stamp_n;
			min_q        <= min_n;
			max_q        <= max_n;
			fly_q        <= fly_n;
			off_q        <= off_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!status_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_n;
		end
	end

	assign status_valid = valid_s2;
	assign status       = status_s2;

endmodule

### hw/rtl/bpss_led.sv
// LED on/off time from the charge level of the battery voltage.
// Depends on bpss_pkg for the level table and the led_cfg_t bundle.
module bpss_led #(
	parameter int LEVEL_STEPS = 10
) (
	input  logic [bpss_pkg::MV_W-1:0]  battery_mv,
	input  bpss_pkg::led_cfg_t         led_cfg,
	output logic [bpss_pkg::CYC_W-1:0] led_on_ms,
	output logic [bpss_pkg::CYC_W-1:0] led_off_ms
);

	localparam int LEVEL_W = $clog2(LEVEL_STEPS);

	logic [LEVEL_W-1:0]              level;
	logic [bpss_pkg::CYC_W-1:0]      period;
	logic [bpss_pkg::CYC_W-1:0]      step;
	logic [bpss_pkg::CYC_W+LEVEL_W-1:0] prod;

	always_comb begin
		level = '0;
		for (int j = 0; j < LEVEL_STEPS - 1; j++) begin
			if (battery_mv > bpss_pkg::level_mv(bpss_pkg::TABLE_W'(j))) begin
				level = level + LEVEL_W'(1);
			end
		end
	end

	assign period     = led_cfg.use_fast ? led_cfg.fast_period : led_cfg.slow_period;
	assign step       = led_cfg.use_fast ? led_cfg.fast_step : led_cfg.slow_step;
	assign prod       = level * step;
	assign led_on_ms  = prod[bpss_pkg::CYC_W-1:0];
	assign led_off_ms = period - led_on_ms;

endmodule
